/* sv/utf8sv_pkg.sv */
package utf8sv_pkg;

    // Error codes reported in the result item.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CONT_EXP  = 3'd1;
    localparam logic [2:0] ERR_NUL       = 3'd2;
    localparam logic [2:0] ERR_FE_FF     = 3'd3;
    localparam logic [2:0] ERR_STRAY     = 3'd4;
    localparam logic [2:0] ERR_OVERLONG  = 3'd5;
    localparam logic [2:0] ERR_CONTROL   = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED = 3'd7;

    // Data-bit masks of the first continuation byte for the overlong test.
    localparam logic [5:0] MASK_THREE = 6'h20;
    localparam logic [5:0] MASK_FOUR  = 6'h30;
    localparam logic [5:0] MASK_FIVE  = 6'h38;
    localparam logic [5:0] MASK_SIX   = 6'h3C;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] error_code;
        logic       string_done;
    } t_out_item;

endpackage

/* sv/utf8sv_judge.sv */
module utf8sv_judge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  utf8sv_pkg::t_in_item i_item,
    output utf8sv_pkg::t_out_item o_result
);

    logic [2:0] r_pend,    n_pend;
    logic       r_armed,   n_armed;
    logic [5:0] r_mask,    n_mask;
    logic [2:0] r_latched, n_latched;

    logic [7:0] b;
    logic [2:0] judge_err;
    logic [2:0] j_pend;
    logic       j_armed;
    logic [5:0] j_mask;

    assign b = i_item.data_byte;

    // Judge one byte against the current sequence state.
    always_comb begin
        judge_err = utf8sv_pkg::ERR_NONE;
        j_pend    = r_pend;
        j_armed   = r_armed;
        j_mask    = r_mask;
        if (r_pend != 3'd0) begin
            if (b[7:6] != 2'b10) begin
                judge_err = utf8sv_pkg::ERR_CONT_EXP;
            end else if (r_armed && ((b[5:0] & r_mask) == 6'd0)) begin
                judge_err = utf8sv_pkg::ERR_OVERLONG;
            end else begin
                j_pend  = r_pend - 3'd1;
                j_armed = 1'b0;
                j_mask  = 6'd0;
            end
        end else if (b == 8'h00) begin
            judge_err = utf8sv_pkg::ERR_NUL;
        end else if (b == 8'hFE || b == 8'hFF) begin
            judge_err = utf8sv_pkg::ERR_FE_FF;
        end else if (b[7]) begin
            if (!b[6]) begin
                judge_err = utf8sv_pkg::ERR_STRAY;
            end else if (!b[5]) begin
                if (b[4:1] == 4'd0) begin
                    judge_err = utf8sv_pkg::ERR_OVERLONG;
                end else begin
                    j_pend  = 3'd1;
                    j_armed = 1'b0;
                    j_mask  = 6'd0;
                end
            end else if (!b[4]) begin
                j_pend  = 3'd2;
                j_armed = (b[3:0] == 4'd0);
                j_mask  = j_armed ? utf8sv_pkg::MASK_THREE : 6'd0;
            end else if (!b[3]) begin
                j_pend  = 3'd3;
                j_armed = (b[2:0] == 3'd0);
                j_mask  = j_armed ? utf8sv_pkg::MASK_FOUR : 6'd0;
            end else if (!b[2]) begin
                j_pend  = 3'd4;
                j_armed = (b[1:0] == 2'd0);
                j_mask  = j_armed ? utf8sv_pkg::MASK_FIVE : 6'd0;
            end else begin
                // Six-octet lead; FE and FF were rejected above.
                j_pend  = 3'd5;
                j_armed = !b[0];
                j_mask  = j_armed ? utf8sv_pkg::MASK_SIX : 6'd0;
            end
        end else if (b < 8'h20 || b == 8'h7F) begin
            judge_err = utf8sv_pkg::ERR_CONTROL;
        end
    end

    // Latch the first error, check for a cut-off sequence, clear at string end.
    always_comb begin
        n_pend    = r_pend;
        n_armed   = r_armed;
        n_mask    = r_mask;
        n_latched = r_latched;
        if (r_latched == utf8sv_pkg::ERR_NONE) begin
            if (judge_err != utf8sv_pkg::ERR_NONE) begin
                n_latched = judge_err;
                n_pend    = 3'd0;
                n_armed   = 1'b0;
                n_mask    = 6'd0;
            end else begin
                n_pend  = j_pend;
                n_armed = j_armed;
                n_mask  = j_mask;
            end
        end
        if (i_item.last_byte && n_latched == utf8sv_pkg::ERR_NONE && n_pend != 3'd0) begin
            n_latched = utf8sv_pkg::ERR_TRUNCATED;
        end
        o_result.error_code  = n_latched;
        o_result.string_done = i_item.last_byte;
        if (i_item.last_byte) begin
            n_pend    = 3'd0;
            n_armed   = 1'b0;
            n_mask    = 6'd0;
            n_latched = utf8sv_pkg::ERR_NONE;
        end
    end

    // Sequence state moves only when the item passes to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 3'd0;
            r_armed   <= 1'b0;
            r_mask    <= 6'd0;
            r_latched <= utf8sv_pkg::ERR_NONE;
        end else if (i_advance) begin
            r_pend    <= n_pend;
            r_armed   <= n_armed;
            r_mask    <= n_mask;
            r_latched <= n_latched;
        end
    end

endmodule

/* sv/utf8_stream_validator_core.sv */
// UTF-8 stream validator (legacy forms of two to six octets).
// Input channel: one byte of a string per item, with last_byte set on the
// final byte. Output channel: one result item per input item, giving the
// first error seen so far in the string and string_done, which copies
// last_byte; on a done item the error code is the verdict for the string.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// An accepted item sits in the input register, is judged, and moves into
// the result register once that register is free or its item is taken.
// Throughput: one byte per cycle unless stalled; the per-byte decision is short
// combinational logic between the input and result registers.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; further input is stalled only once
// both are full.
// Reset clears both valid flags and the sequence state; the first item
// after reset starts a new string.
module utf8_stream_validator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  utf8sv_pkg::t_in_item  i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output utf8sv_pkg::t_out_item o_out_item,
    input  logic                  i_out_stall
);

    logic                  r_in_valid;
    utf8sv_pkg::t_in_item  r_in_item;
    logic                  r_out_valid;
    utf8sv_pkg::t_out_item r_out_item;

    logic                  advance;
    logic                  in_take;
    utf8sv_pkg::t_out_item judged;

    // Handshake: the input register drains whenever the result register frees.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    utf8sv_judge u_judge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (judged)
    );

    // Valid flags of the two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= judged;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* test/utf8_stream_validator_core_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the validator, predicts the verdict of every
// accepted byte, and compares each result item with the oldest prediction.
module utf8_stream_validator_core_checker
    import utf8sv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_item i_out_item,
    input  logic      i_out_stall,
    output int        o_mismatch_count,
    output int        o_outstanding
);

    // Sequence state of the predicted validator.
    logic [2:0] seq_pending;
    logic       seq_armed;
    logic [5:0] seq_mask;
    logic [2:0] seq_error;

    t_out_item expected_verdicts[$];
    int        mismatch_count = 0;

    initial begin
        o_mismatch_count = 0;
        o_outstanding    = 0;
    end

    // Loads the sequence state for a lead byte.
    function automatic void open_sequence(input logic [2:0] count, input logic check,
                                          input logic [5:0] mask);
        seq_pending = count;
        seq_armed   = check;
        seq_mask    = check ? mask : 6'd0;
    endfunction

    // Judges one byte against the current sequence state and returns its error.
    function automatic logic [2:0] judge_utf8_byte(input logic [7:0] b);
        if (seq_pending != 3'd0) begin
            if (b[7:6] != 2'b10) return ERR_CONT_EXP;
            if (seq_armed && (b[5:0] & seq_mask) == 6'd0) return ERR_OVERLONG;
            seq_armed   = 1'b0;
            seq_mask    = 6'd0;
            seq_pending = seq_pending - 3'd1;
            return ERR_NONE;
        end
        if (b == 8'h00) return ERR_NUL;
        if (b == 8'hFE || b == 8'hFF) return ERR_FE_FF;
        if (b[7]) begin
            if (b[7:6] == 2'b10) return ERR_STRAY;
            if (b[7:5] == 3'b110) begin
                if (b[4:1] == 4'd0) return ERR_OVERLONG;
                open_sequence(3'd1, 1'b0, 6'd0);
            end else if (b[7:4] == 4'b1110) begin
                open_sequence(3'd2, b[3:0] == 4'd0, MASK_THREE);
            end else if (b[7:3] == 5'b11110) begin
                open_sequence(3'd3, b[2:0] == 3'd0, MASK_FOUR);
            end else if (b[7:2] == 6'b111110) begin
                open_sequence(3'd4, b[1:0] == 2'd0, MASK_FIVE);
            end else begin
                open_sequence(3'd5, b[0] == 1'b0, MASK_SIX);
            end
            return ERR_NONE;
        end
        if (b < 8'h20 || b == 8'h7F) return ERR_CONTROL;
        return ERR_NONE;
    endfunction

    // Advances the predicted state by one byte and forms its result item.
    function automatic t_out_item predict_verdict(input t_in_item item);
        t_out_item verdict;
        logic [2:0] err;
        if (seq_error == ERR_NONE) begin
            err = judge_utf8_byte(item.data_byte);
            if (err != ERR_NONE) begin
                seq_error = err;
                open_sequence(3'd0, 1'b0, 6'd0);
            end
        end
        if (item.last_byte && seq_error == ERR_NONE && seq_pending != 3'd0)
            seq_error = ERR_TRUNCATED;
        verdict.error_code  = seq_error;
        verdict.string_done = item.last_byte;
        // The last byte closes the string and clears everything.
        if (item.last_byte) begin
            open_sequence(3'd0, 1'b0, 6'd0);
            seq_error = ERR_NONE;
        end
        return verdict;
    endfunction

    // Compare results first, then record the prediction for a new byte.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            open_sequence(3'd0, 1'b0, 6'd0);
            seq_error = ERR_NONE;
            expected_verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result item with no expected verdict waiting");
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_out_item.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               want.error_code, i_out_item.error_code);
                        mismatch_count++;
                    end
                    if (i_out_item.string_done !== want.string_done) begin
                        $error("string_done: expected %0d, actual %0d",
                               want.string_done, i_out_item.string_done);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_verdicts.push_back(predict_verdict(i_in_item));
        end
        o_mismatch_count <= mismatch_count;
        o_outstanding    <= expected_verdicts.size();
    end

endmodule

/* test/utf8_stream_validator_core_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_validator_core_tb;
    import utf8sv_pkg::*;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;
    logic      quiet     = 1'b0;

    int        mismatch_count;
    int        outstanding;
    int        bytes_sent = 0;
    logic      pressure_done = 1'b0;
    logic [7:0] string_bytes[$];

    utf8_stream_validator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    utf8_stream_validator_core_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_item        (in_item),
        .i_in_stall       (in_stall),
        .i_out_valid      (out_valid),
        .i_out_item       (out_item),
        .i_out_stall      (out_stall),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random except during the quiet stretch.
    always @(posedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 36);
    end

    // Offers one byte, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item item;
        while (!quiet && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        item.data_byte = b;
        item.last_byte = last;
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends the bytes collected in string_bytes as one string.
    task automatic send_string();
        for (int i = 0; i < string_bytes.size(); i++)
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
    endtask

    // Appends one random character: mostly well-formed, sometimes noise or broken.
    task automatic append_char();
        int         kind;
        int         n;
        logic [7:0] lead;
        logic [7:0] payload_mask;
        logic [7:0] cont;
        kind = $urandom_range(99);
        if (kind < 40) begin
            string_bytes.push_back(8'($urandom_range(8'h7E, 8'h20)));
        end else if (kind < 52) begin
            case ($urandom_range(4))
                0: string_bytes.push_back(8'($urandom_range(8'h1F, 8'h00)));
                1: string_bytes.push_back(8'h7F);
                2: string_bytes.push_back(8'($urandom_range(8'hFF, 8'hFE)));
                3: string_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                default: string_bytes.push_back(8'($urandom_range(255)));
            endcase
        end else begin
            // Multi-octet sequence; lead and first continuation lean toward
            // the overlong boundary.
            n = $urandom_range(6, 2);
            lead = 8'hFF << (8 - n);
            payload_mask = (8'd1 << (7 - n)) - 8'd1;
            if ($urandom_range(3) == 0)
                lead = lead | (n == 2 ? 8'($urandom_range(1)) : 8'd0);
            else
                lead = lead | (8'($urandom) & payload_mask);
            string_bytes.push_back(lead);
            for (int i = 1; i < n; i++) begin
                if (i == 1 && $urandom_range(3) == 0)
                    cont = 8'h80 | (8'($urandom_range(3)) << (6 - n + 1 > 0 ? 6 - n : 0));
                else
                    cont = 8'h80 | 8'($urandom_range(63));
                if ($urandom_range(29) == 0)
                    cont = 8'($urandom_range(255));
                string_bytes.push_back(cont);
            end
        end
    endtask

    // Builds a random string, sometimes cut short by dropping bytes from its end.
    task automatic send_random_string();
        int chars;
        int cut;
        string_bytes.delete();
        chars = $urandom_range(6, 1);
        for (int i = 0; i < chars; i++)
            append_char();
        if ($urandom_range(9) == 0 && string_bytes.size() > 1) begin
            cut = $urandom_range(string_bytes.size() - 1, 1);
            for (int i = 0; i < cut; i++)
                void'(string_bytes.pop_back());
        end
        send_string();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: each error kind, each sequence length, and the
        // truncated, bad-continuation and after-error cases.
        string_bytes = {8'h41, 8'h7E};               send_string();
        string_bytes = {8'h01};                      send_string();
        string_bytes = {8'h1F};                      send_string();
        string_bytes = {8'h7F};                      send_string();
        string_bytes = {8'h00};                      send_string();
        string_bytes = {8'hFE};                      send_string();
        string_bytes = {8'hFF};                      send_string();
        string_bytes = {8'h80};                      send_string();
        string_bytes = {8'hC0, 8'h80};               send_string();
        string_bytes = {8'hE0, 8'h80, 8'h80};        send_string();
        string_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string();
        string_bytes = {8'hFC, 8'h80};               send_string();
        string_bytes = {8'hC2, 8'h41};               send_string();
        string_bytes = {8'hF8, 8'h88};               send_string();

        // Random strings, with one quiet stretch and one full drain midway.
        while (bytes_sent < 900) begin
            if (bytes_sent >= 550 && bytes_sent < 700)
                quiet <= 1'b1;
            else
                quiet <= 1'b0;
            if (!pressure_done && bytes_sent >= 400) begin
                pressure_done = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) @(posedge i_clk);
            end
            send_random_string();
        end

        // Drain the remaining results, then give the verdict.
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
sv/utf8sv_pkg.sv
sv/utf8sv_judge.sv
sv/utf8_stream_validator_core.sv
test/utf8_stream_validator_core_checker.sv
test/utf8_stream_validator_core_tb.sv
